/* rtl/assert_macros.svh */
// Assertion macros used by the segment writer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/declcd_pkg.sv */
// Package: transaction types, sizes and the digit segment table.
package declcd_pkg;

    localparam int VALUE_WIDTH = 32;
    localparam int PROD_WIDTH  = VALUE_WIDTH + 32;
    localparam int DIV_SHIFT   = 35;
    localparam int QUO_WIDTH   = PROD_WIDTH - DIV_SHIFT;
    localparam logic [31:0] RECIP_TEN = 32'hCCCC_CCCD;

    localparam int NUM_COLS = 3;
    localparam int NUM_ROWS = 4;
    localparam int IMG_DEPTH = NUM_COLS * NUM_ROWS;

    localparam logic       OP_NUMBER   = 1'b0;
    localparam logic       OP_DIGIT    = 1'b1;
    localparam logic [2:0] POS_RIGHT   = 3'd5;
    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_NINE  = 8'h39;
    localparam logic [7:0] RAW_NINE    = 8'h09;
    localparam logic [7:0] HIGH_MASK   = 8'hF0;
    localparam logic [7:0] LOW_MASK    = 8'h0F;

    typedef struct packed {
        logic               opcode;
        logic signed [31:0] value;
        logic [7:0]         digit_char;
        logic [2:0]         position;
    } cmd_t;

    typedef struct packed {
        logic [4:0] register_index;
        logic [7:0] byte_value;
        logic       last;
    } seg_t;

    // Segment word for a decimal digit, row 0 in the low nibble.
    function automatic logic [15:0] seg_word(input logic [3:0] d);
        logic [15:0] w;
        unique case (d)
            4'd0:    w = 16'h1551;
            4'd1:    w = 16'h0110;
            4'd2:    w = 16'h1E11;
            4'd3:    w = 16'h1B11;
            4'd4:    w = 16'h0B50;
            4'd5:    w = 16'h1B41;
            4'd6:    w = 16'h1F41;
            4'd7:    w = 16'h0111;
            4'd8:    w = 16'h1F51;
            4'd9:    w = 16'h0B51;
            default: w = 16'h0000;
        endcase
        return w;
    endfunction

endpackage

/* rtl/decimal_to_lcd_segment_writer.sv */
// Top level: LCD segment image writer with read-modify-write sequencer.
// Usage:
//   The cmd channel takes one transaction per command. Opcode 0 shows a
//   positive number right-aligned from position 5; opcode 1 writes one
//   digit (raw or ASCII) at position 0..5. Invalid commands are dropped.
//   Every image byte written leaves on the seg channel as one transaction
//   (register index, new byte, last flag on the final byte of a command).
// Sequence:
//   A digit takes 4 rows, each a memory read then a write, and a number
//   digit first passes the divide-by-ten states (S_DIV, S_REM). A dropped
//   command is taken while cmd_stall is low and leaves the sequencer idle.
//   The single-port image memory does one read or one write at a time.
//   The first byte goes to the seg register when the first row is written.
//   One command is worked at a time; cmd_stall is high while one is busy.
// Reset:
//   The image reads as all zeros (blank) after reset through per-entry
//   valid bits; no clearing pass is needed. The sequencer returns to idle.
// Stall:
//   When seg_stall holds the output register, the sequencer waits on the
//   pending write, and the image is left untouched until the byte moves.
module decimal_to_lcd_segment_writer
    import declcd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic cmd_valid,
    output logic cmd_stall,
    input  cmd_t cmd,
    output logic seg_valid,
    input  logic seg_stall,
    output seg_t seg
);

`include "assert_macros.svh"

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_DIV   = 3'd1;
    localparam logic [2:0] S_REM   = 3'd2;
    localparam logic [2:0] S_READ  = 3'd3;
    localparam logic [2:0] S_WRITE = 3'd4;

    logic [2:0]              state_reg, state_next;
    logic [VALUE_WIDTH-1:0]  val_reg, val_next;
    logic [PROD_WIDTH-1:0]   prod_reg;
    logic [3:0]              dig_reg, dig_next;
    logic [2:0]              pos_reg, pos_next;
    logic [1:0]              row_reg, row_next;
    logic                    done_reg, done_next;
    logic                    out_valid_reg;
    seg_t                    out_reg;
    seg_t                    out_next;
    logic                    out_load;

    logic [7:0]              mem [0:IMG_DEPTH-1];
    logic [IMG_DEPTH-1:0]    mem_vld_reg;
    logic [7:0]              rd_reg;
    logic                    rd_vld_reg;
    logic [3:0]              slot;
    logic                    mem_re;
    logic                    mem_we;
    logic [7:0]              old_byte;
    logic [7:0]              new_byte;
    logic [3:0]              nib;
    logic [15:0]             word;

    logic                    cmd_take;
    logic [VALUE_WIDTH-1:0]  cmd_val;
    logic                    char_ascii;
    logic                    char_raw;
    logic [7:0]              char_dig;
    logic [QUO_WIDTH-1:0]    quo;
    logic [VALUE_WIDTH-1:0]  quo_ext;
    logic [VALUE_WIDTH-1:0]  quo_ten;
    logic [VALUE_WIDTH-1:0]  rem_full;

    assign cmd_stall = (state_reg != S_IDLE);
    assign cmd_take  = cmd_valid && !cmd_stall;
    assign cmd_val   = cmd.value[VALUE_WIDTH-1:0];
    assign char_ascii = (cmd.digit_char >= ASCII_ZERO) && (cmd.digit_char <= ASCII_NINE);
    assign char_raw   = (cmd.digit_char <= RAW_NINE);
    assign char_dig   = char_ascii ? (cmd.digit_char - ASCII_ZERO) : cmd.digit_char;

    // Quotient and remainder by ten from the registered reciprocal product
    assign quo      = prod_reg[PROD_WIDTH-1:DIV_SHIFT];
    assign quo_ext  = VALUE_WIDTH'(quo);
    assign quo_ten  = (quo_ext << 3) + (quo_ext << 1);
    assign rem_full = val_reg - quo_ten;

    // Image slot and register number for the current column and row
    assign slot = {2'b00, pos_reg[2:1]} + {1'b0, row_reg, 1'b0} + {2'b00, row_reg};

    assign word     = seg_word(dig_reg);
    assign nib      = word[4*row_reg +: 4];
    assign old_byte = rd_vld_reg ? rd_reg : 8'h00;
    assign new_byte = pos_reg[0] ? ((old_byte & LOW_MASK) | {nib, 4'h0})
                                 : ((old_byte & HIGH_MASK) | {4'h0, nib});

    assign out_next.register_index = {3'b000, pos_reg[2:1]} + {1'b0, row_reg, 2'b00}
                                   + {3'b000, row_reg};
    assign out_next.byte_value     = new_byte;
    assign out_next.last           = (row_reg == 2'd3) && done_reg;

    assign out_load = (state_reg == S_WRITE) && (!out_valid_reg || !seg_stall);
    assign mem_re   = (state_reg == S_READ);
    assign mem_we   = out_load;

    // Sequence commands through divide, read and write steps
    always_comb
    begin
        state_next = state_reg;
        val_next   = val_reg;
        dig_next   = dig_reg;
        pos_next   = pos_reg;
        row_next   = row_reg;
        done_next  = done_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (cmd_take)
                begin
                    row_next = 2'd0;
                    if (cmd.opcode == OP_NUMBER)
                    begin
                        val_next = cmd_val;
                        pos_next = POS_RIGHT;
                        if (!cmd_val[VALUE_WIDTH-1] && (cmd_val != '0))
                        begin
                            state_next = S_DIV;
                        end
                    end
                    else
                    begin
                        dig_next  = char_dig[3:0];
                        pos_next  = cmd.position;
                        done_next = 1'b1;
                        if ((char_ascii || char_raw) && (cmd.position <= POS_RIGHT))
                        begin
                            state_next = S_READ;
                        end
                    end
                end
            end
            S_DIV:
            begin
                state_next = S_REM;
            end
            S_REM:
            begin
                dig_next   = rem_full[3:0];
                val_next   = quo_ext;
                done_next  = (quo == '0) || (pos_reg == 3'd0);
                state_next = S_READ;
            end
            S_READ:
            begin
                state_next = S_WRITE;
            end
            S_WRITE:
            begin
                if (out_load)
                begin
                    row_next = row_reg + 2'd1;
                    if (row_reg != 2'd3)
                    begin
                        state_next = S_READ;
                    end
                    else if (done_reg)
                    begin
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        pos_next   = pos_reg - 3'd1;
                        state_next = S_DIV;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Advance control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            row_reg       <= 2'd0;
            done_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            mem_vld_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            done_reg  <= done_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!seg_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            if (mem_we)
            begin
                mem_vld_reg[slot] <= 1'b1;
            end
        end
    end

    // Hold datapath registers
    always_ff @(posedge clk)
    begin
        val_reg  <= val_next;
        dig_reg  <= dig_next;
        pos_reg  <= pos_next;
        prod_reg <= val_reg * RECIP_TEN;
        if (out_load)
        begin
            out_reg <= out_next;
        end
    end

    // Image memory: one read or one write per cycle, registered read data
    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[slot] <= new_byte;
        end
        if (mem_re)
        begin
            rd_reg     <= mem[slot];
            rd_vld_reg <= mem_vld_reg[slot];
        end
    end

    assign seg_valid = out_valid_reg;
    assign seg       = out_reg;

    `ASSERT_SAME(a_row_mid_digit, clk, rst_n, row_reg != 2'd0,
        (state_reg == S_READ) || (state_reg == S_WRITE))
    `ASSERT_NEXT(a_last_to_idle, clk, rst_n, out_load && out_next.last,
        state_reg == S_IDLE)
    `ASSERT_SAME(a_write_follows_read, clk, rst_n, state_reg == S_WRITE,
        $past(state_reg) == S_READ || $past(state_reg) == S_WRITE)
    `ASSERT_NEXT(a_write_moves_out, clk, rst_n, mem_we, out_valid_reg)

endmodule

/* bench/decimal_to_lcd_segment_writer_tb.sv */
// Testbench for the decimal-to-LCD segment writer: directed and random commands, self-checking.
module decimal_to_lcd_segment_writer_tb;
    import declcd_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES   = 100;

    // Segment word per decimal digit, row 0 in the low nibble
    localparam logic [15:0] DIGIT_SEGMENTS [10] = '{
        16'h1551, 16'h0110, 16'h1E11, 16'h1B11, 16'h0B50,
        16'h1B41, 16'h1F41, 16'h0111, 16'h1F51, 16'h0B51
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cmd_valid = 1'b0;
    logic cmd_stall;
    cmd_t cmd = '0;
    logic seg_valid;
    logic seg_stall = 1'b0;
    seg_t seg;

    // Predicted image and the register writes still to arrive
    logic [7:0] lcd_image [IMG_DEPTH];
    seg_t fresh_writes [$];
    seg_t expected_writes [$];
    seg_t want;

    int fail_count = 0;
    int send_gap_max = 10;
    int recv_gap_max = 10;
    int hold_cycles = 0;
    int idle_count = 0;

    decimal_to_lcd_segment_writer dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (cmd_valid),
        .cmd_stall (cmd_stall),
        .cmd       (cmd),
        .seg_valid (seg_valid),
        .seg_stall (seg_stall),
        .seg       (seg)
    );

    always #5 clk = ~clk;

    // Update one digit in the image, queue the four byte writes it makes
    task automatic paint_digit(input logic [3:0] d, input logic [2:0] pos);
        logic [1:0] col;
        logic [15:0] word;
        logic [3:0] nib;
        int slot;
        int row;
        seg_t w;
        col = pos[2:1];
        word = DIGIT_SEGMENTS[d];
        for (row = 0; row < NUM_ROWS; row++)
        begin
            slot = col + NUM_COLS * row;
            nib = word[4 * row +: 4];
            if (pos[0])
                lcd_image[slot] = (lcd_image[slot] & LOW_MASK) | {nib, 4'h0};
            else
                lcd_image[slot] = (lcd_image[slot] & HIGH_MASK) | {4'h0, nib};
            w.register_index = 5'(col + 5 * row);
            w.byte_value = lcd_image[slot];
            w.last = 1'b0;
            fresh_writes.push_back(w);
        end
    endtask

    // Work out the register writes one accepted command causes
    task automatic predict_writes(input cmd_t c);
        logic [31:0] remaining;
        logic [2:0] pos;
        logic [7:0] ch;
        logic [3:0] d;
        bit ok;
        int left;
        int i;
        seg_t w;
        fresh_writes.delete();
        if (c.opcode == OP_NUMBER)
        begin
            remaining = 32'(c.value[VALUE_WIDTH-1:0]);
            if (!remaining[VALUE_WIDTH-1])
            begin
                pos = POS_RIGHT;
                left = 6;
                while (remaining != 0 && left > 0)
                begin
                    paint_digit(4'(remaining % 10), pos);
                    remaining = remaining / 10;
                    pos = pos - 3'd1;
                    left--;
                end
            end
        end
        else
        begin
            ch = c.digit_char;
            ok = 1'b1;
            d = '0;
            if (ch >= ASCII_ZERO && ch <= ASCII_NINE)
                d = 4'(ch - ASCII_ZERO);
            else if (ch <= RAW_NINE)
                d = ch[3:0];
            else
                ok = 1'b0;
            if (c.position > POS_RIGHT)
                ok = 1'b0;
            if (ok)
                paint_digit(d, c.position);
        end
        for (i = 0; i < fresh_writes.size(); i++)
        begin
            w = fresh_writes[i];
            w.last = (i == fresh_writes.size() - 1);
            expected_writes.push_back(w);
        end
    endtask

    function automatic cmd_t make_cmd(input logic op, input logic [31:0] v,
                                      input logic [7:0] ch, input logic [2:0] pos);
        cmd_t c;
        c.opcode = op;
        c.value = v;
        c.digit_char = ch;
        c.position = pos;
        return c;
    endfunction

    // Offer one command after a random gap, hold it until accepted
    task automatic send_command(input cmd_t c);
        int gap;
        gap = $urandom_range(0, send_gap_max);
        if (gap > 0)
        begin
            cmd_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cmd_valid <= 1'b1;
        cmd <= c;
        do @(posedge clk); while (cmd_stall !== 1'b0);
        predict_writes(c);
    endtask

    // Number with a random count of decimal digits, sometimes zero or negative
    function automatic logic [31:0] pick_number();
        int k;
        longint unsigned span;
        logic [31:0] v;
        k = $urandom_range(0, 11);
        if (k == 0)
            v = $urandom_range(0, 1) ? 32'h0 : ($urandom | 32'h8000_0000);
        else if (k == 11)
            v = $urandom & 32'h7FFF_FFFF;
        else
        begin
            span = 1;
            repeat (k) span = span * 10;
            v = 32'(longint'($urandom) % span);
        end
        return v;
    endfunction

    function automatic cmd_t pick_digit_cmd();
        logic [7:0] ch;
        logic [2:0] pos;
        if ($urandom_range(0, 9) < 7)
        begin
            ch = 8'($urandom_range(0, 9));
            if ($urandom_range(0, 1))
                ch = ch + ASCII_ZERO;
            pos = 3'($urandom_range(0, 5));
        end
        else
        begin
            ch = 8'($urandom_range(0, 255));
            pos = 3'($urandom_range(0, 7));
        end
        return make_cmd(OP_DIGIT, $urandom, ch, pos);
    endfunction

    task automatic test_directed_numbers();
        send_command(make_cmd(OP_NUMBER, 32'd0, 8'hFF, 3'd7));
        send_command(make_cmd(OP_NUMBER, 32'hFFFF_FFFF, 8'h00, 3'd0));
        send_command(make_cmd(OP_NUMBER, 32'h8000_0000, 8'h35, 3'd2));
        send_command(make_cmd(OP_NUMBER, 32'h7FFF_FFFF, 8'h00, 3'd0));
        send_command(make_cmd(OP_NUMBER, 32'd1, 8'h00, 3'd0));
        send_command(make_cmd(OP_NUMBER, 32'd9, 8'hAA, 3'd5));
        send_command(make_cmd(OP_NUMBER, 32'd123456, 8'h00, 3'd0));
        send_command(make_cmd(OP_NUMBER, 32'd10, 8'h00, 3'd0));
        send_command(make_cmd(OP_NUMBER, 32'd1234567, 8'h55, 3'd3));
        send_command(make_cmd(OP_NUMBER, 32'd100000, 8'h00, 3'd1));
        send_command(make_cmd(OP_NUMBER, 32'd987, 8'h00, 3'd0));
    endtask

    task automatic test_directed_digits();
        send_command(make_cmd(OP_DIGIT, 32'hFFFF_FFFF, 8'd0, 3'd0));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'd9, 3'd5));
        send_command(make_cmd(OP_DIGIT, 32'd0, ASCII_ZERO, 3'd1));
        send_command(make_cmd(OP_DIGIT, 32'h8000_0000, ASCII_NINE, 3'd4));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'd4, 3'd2));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'h37, 3'd3));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'd10, 3'd0));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'h2F, 3'd1));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'h3A, 3'd2));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'hFF, 3'd3));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'd5, 3'd6));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'h36, 3'd7));
        send_command(make_cmd(OP_DIGIT, 32'd0, 8'd8, 3'd0));
    endtask

    // Hold the output off for a long stretch while commands keep coming
    task automatic test_output_backpressure();
        int n;
        send_gap_max = 0;
        hold_cycles = 300;
        for (n = 0; n < 20; n++)
        begin
            if (n % 2 == 0)
                send_command(make_cmd(OP_NUMBER, pick_number(), 8'($urandom),
                                      3'($urandom)));
            else
                send_command(pick_digit_cmd());
        end
        send_gap_max = 10;
    endtask

    task automatic test_random_traffic();
        int chunk;
        int n;
        for (chunk = 0; chunk < 10; chunk++)
        begin
            // every fourth stretch runs with no idling on either side
            send_gap_max = (chunk % 4 == 3) ? 0 : ((chunk % 2) ? 3 : 10);
            recv_gap_max = (chunk % 4 == 3) ? 0 : ((chunk % 3) ? 10 : 2);
            for (n = 0; n < 43; n++)
            begin
                if ($urandom_range(0, 9) < 4)
                    send_command(make_cmd(OP_NUMBER, pick_number(), 8'($urandom),
                                          3'($urandom)));
                else
                    send_command(pick_digit_cmd());
            end
        end
        send_gap_max = 10;
        recv_gap_max = 10;
    endtask

    // Receiver: random stall before each transaction, plus requested long holds
    initial
    begin : receiver
        int n;
        forever
        begin
            if (hold_cycles > 0)
            begin
                n = hold_cycles;
                hold_cycles = 0;
            end
            else
                n = $urandom_range(0, recv_gap_max);
            if (n > 0)
            begin
                seg_stall <= 1'b1;
                repeat (n) @(posedge clk);
            end
            seg_stall <= 1'b0;
            do @(posedge clk); while (!(seg_valid === 1'b1 && seg_stall === 1'b0));
        end
    end

    // Compare each accepted write with the oldest expectation
    always @(posedge clk)
    begin
        if (rst_n && seg_valid === 1'b1 && seg_stall === 1'b0)
        begin
            if (expected_writes.size() == 0)
            begin
                $display("%0t: unexpected write: expected none, actual idx %0d byte %h last %b",
                         $time, seg.register_index, seg.byte_value, seg.last);
                fail_count++;
            end
            else
            begin
                want = expected_writes.pop_front();
                if (seg.register_index !== want.register_index)
                begin
                    $display("%0t: register_index mismatch: expected %0d, actual %0d",
                             $time, want.register_index, seg.register_index);
                    fail_count++;
                end
                if (seg.byte_value !== want.byte_value)
                begin
                    $display("%0t: byte_value mismatch: expected %h, actual %h",
                             $time, want.byte_value, seg.byte_value);
                    fail_count++;
                end
                if (seg.last !== want.last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, seg.last);
                    fail_count++;
                end
            end
        end
    end

    // Watchdog: end the run when nothing moves for too long
    initial
    begin : watchdog
        while (idle_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((cmd_valid === 1'b1 && cmd_stall === 1'b0) ||
                (seg_valid === 1'b1 && seg_stall === 1'b0))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("%0t: watchdog expired, %0d writes outstanding",
                 $time, expected_writes.size());
        $display("Test completed with failures");
        $finish;
    end

    initial
    begin : main
        int i;
        for (i = 0; i < IMG_DEPTH; i++)
            lcd_image[i] = 8'h00;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_numbers();
        test_directed_digits();
        test_output_backpressure();
        test_random_traffic();

        // drain and let the block settle
        cmd_valid <= 1'b0;
        while (expected_writes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_writes.size() == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
